// File: rtl/ddpi_pkg.sv
// ----------------------------------------------------------------------------
// ddpi_pkg
// Types, microcode program and arctangent table shared by the pose
// integrator's sequencer and datapath.
// ----------------------------------------------------------------------------
package ddpi_pkg;

    localparam int PC_W         = 3;
    localparam int ITER_W       = 5;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    typedef logic [PC_W-1:0]   t_pc;
    typedef logic [ITER_W-1:0] t_iter;

    // datapath operations, one per control word
    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_HEAD = 3'd1,
        OP_ROT  = 3'd2,
        OP_FLIP = 3'd3,
        OP_MUL1 = 3'd4,
        OP_MUL2 = 3'd5,
        OP_ACC  = 3'd6,
        OP_OUT  = 3'd7
    } t_op;

    // jump conditions; a true condition loads the target, else the step advances
    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_NO_IN    = 2'd1,
        COND_NOT_LAST = 2'd2,
        COND_OUT_BUSY = 2'd3
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic ready;
        logic take;
    } t_ctl;

    typedef struct packed {
        logic iter_last;
        logic out_busy;
    } t_sts;

    localparam t_pc STEP_IDLE = 3'd0;
    localparam t_pc STEP_HEAD = 3'd1;
    localparam t_pc STEP_ROT  = 3'd2;
    localparam t_pc STEP_FLIP = 3'd3;
    localparam t_pc STEP_MUL1 = 3'd4;
    localparam t_pc STEP_MUL2 = 3'd5;
    localparam t_pc STEP_ACC  = 3'd6;
    localparam t_pc STEP_OUT  = 3'd7;

    // control store; the output step falls through to the idle step by wrap
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            STEP_IDLE: w = '{op: OP_LOAD, cond: COND_NO_IN,    target: STEP_IDLE};
            STEP_HEAD: w = '{op: OP_HEAD, cond: COND_NONE,     target: STEP_IDLE};
            STEP_ROT:  w = '{op: OP_ROT,  cond: COND_NOT_LAST, target: STEP_ROT};
            STEP_FLIP: w = '{op: OP_FLIP, cond: COND_NONE,     target: STEP_IDLE};
            STEP_MUL1: w = '{op: OP_MUL1, cond: COND_NONE,     target: STEP_IDLE};
            STEP_MUL2: w = '{op: OP_MUL2, cond: COND_NONE,     target: STEP_IDLE};
            STEP_ACC:  w = '{op: OP_ACC,  cond: COND_NONE,     target: STEP_IDLE};
            STEP_OUT:  w = '{op: OP_OUT,  cond: COND_OUT_BUSY, target: STEP_OUT};
        endcase
        return w;
    endfunction

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [31:0] atan_turn(input t_iter i);
        logic signed [31:0] a;
        unique case (i)
            5'd0:  a = 32'sd536870912;
            5'd1:  a = 32'sd316933406;
            5'd2:  a = 32'sd167458907;
            5'd3:  a = 32'sd85004756;
            5'd4:  a = 32'sd42667331;
            5'd5:  a = 32'sd21354465;
            5'd6:  a = 32'sd10679838;
            5'd7:  a = 32'sd5340245;
            5'd8:  a = 32'sd2670163;
            5'd9:  a = 32'sd1335087;
            5'd10: a = 32'sd667544;
            5'd11: a = 32'sd333772;
            5'd12: a = 32'sd166886;
            5'd13: a = 32'sd83443;
            5'd14: a = 32'sd41722;
            5'd15: a = 32'sd20861;
            5'd16: a = 32'sd10430;
            5'd17: a = 32'sd5215;
            5'd18: a = 32'sd2608;
            5'd19: a = 32'sd1304;
            5'd20: a = 32'sd652;
            5'd21: a = 32'sd326;
            5'd22: a = 32'sd163;
            5'd23: a = 32'sd81;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/ddpi_if.sv
// ----------------------------------------------------------------------------
// ddpi channel interfaces
// Valid/ready channels for motion commands and pose results.
// ----------------------------------------------------------------------------
interface ddpi_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] forward_speed;
    logic signed [23:0] turn_rate;
    logic        [15:0] time_step;

    modport source (output valid, output forward_speed, output turn_rate,
                    output time_step, input ready);
    modport sink   (input valid, input forward_speed, input turn_rate,
                    input time_step, output ready);
endinterface

interface ddpi_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    output ready);
endinterface

// File: rtl/ddpi_seq.sv
// ----------------------------------------------------------------------------
// ddpi_seq
// Step counter and control store: fetch one control word per cycle and
// branch on the input valid and on datapath status.
// ----------------------------------------------------------------------------
module ddpi_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ddpi_pkg::t_sts   i_sts,
    output ddpi_pkg::t_ctl   o_ctl
);

    ddpi_pkg::t_pc    r_pc;
    ddpi_pkg::t_pc    n_pc;
    ddpi_pkg::t_uword w_word;
    logic             w_jump;

    assign w_word = ddpi_pkg::ucode(r_pc);

    always_comb begin
        unique case (w_word.cond)
            ddpi_pkg::COND_NONE:     w_jump = 1'b0;
            ddpi_pkg::COND_NO_IN:    w_jump = !i_in_valid;
            ddpi_pkg::COND_NOT_LAST: w_jump = !i_sts.iter_last;
            ddpi_pkg::COND_OUT_BUSY: w_jump = i_sts.out_busy;
        endcase
        n_pc = w_jump ? w_word.target : ddpi_pkg::t_pc'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ddpi_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.op    = w_word.op;
    assign o_ctl.ready = (w_word.op == ddpi_pkg::OP_LOAD);
    assign o_ctl.take  = (w_word.op == ddpi_pkg::OP_LOAD) && i_in_valid;

endmodule

// File: rtl/ddpi_dp.sv
// ----------------------------------------------------------------------------
// ddpi_dp
// Datapath: heading update, shared CORDIC rotator, displacement multipliers,
// saturating pose accumulators and the result register.
// ----------------------------------------------------------------------------
module ddpi_dp #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ddpi_pkg::t_ctl     i_ctl,
    input  logic signed [23:0] i_forward_speed,
    input  logic signed [23:0] i_turn_rate,
    input  logic        [15:0] i_time_step,
    input  logic               i_out_ready,
    output ddpi_pkg::t_sts     o_sts,
    output logic               o_out_valid,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [15:0] o_heading
);

    localparam ddpi_pkg::t_iter LAST_ITER = ddpi_pkg::t_iter'(CORDIC_STEPS - 1);
    localparam int              PAD_BITS  = 32 - ANGLE_BITS;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = {1'b1, 31'h0};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    // item operands
    logic signed [23:0]           r_v;
    logic        [15:0]           r_dt;
    logic signed [40:0]           r_hprod;
    // pose state
    logic        [ANGLE_BITS-1:0] r_heading;
    logic signed [31:0]           r_x;
    logic signed [31:0]           r_y;
    // CORDIC
    logic signed [31:0]           r_cx;
    logic signed [31:0]           r_cy;
    logic signed [31:0]           r_cz;
    logic                         r_flip;
    ddpi_pkg::t_iter              r_iter;
    // displacement products
    logic signed [55:0]           r_px;
    logic signed [55:0]           r_py;
    logic signed [56:0]           r_dx;
    logic signed [56:0]           r_dy;
    // result register
    logic                         r_out_valid;
    logic signed [31:0]           r_out_x;
    logic signed [31:0]           r_out_y;
    logic signed [15:0]           r_out_h;

    logic signed [41:0]           w_hsum;
    logic        [ANGLE_BITS-1:0] n_heading;
    logic        [31:0]           w_zu;
    logic                         w_flip;
    logic signed [31:0]           w_dx;
    logic signed [31:0]           w_dy;
    logic signed [31:0]           w_atan;
    logic signed [55:0]           w_psx;
    logic signed [55:0]           w_psy;
    logic signed [56:0]           w_dsx;
    logic signed [56:0]           w_dsy;
    logic signed [33:0]           w_sumx;
    logic signed [33:0]           w_sumy;
    logic signed [15:0]           w_h16;
    logic                         w_out_busy;

    // heading increment rounded to nearest, wrapped to the angle width
    assign w_hsum    = {r_hprod[40], r_hprod} + 42'sd32768;
    assign n_heading = r_heading + w_hsum[16 +: ANGLE_BITS];

    // fold the angle into the right half plane, negate the results later
    assign w_zu   = {n_heading, {PAD_BITS{1'b0}}};
    assign w_flip = w_zu[31] ^ w_zu[30];

    assign w_dx   = r_cy >>> r_iter;
    assign w_dy   = r_cx >>> r_iter;
    assign w_atan = ddpi_pkg::atan_turn(r_iter);

    assign w_psx = r_px + 56'sd32768;
    assign w_psy = r_py + 56'sd32768;
    assign w_dsx = r_dx + 57'sd536870912;
    assign w_dsy = r_dy + 57'sd536870912;

    assign w_sumx = {{2{r_x[31]}}, r_x} + {{7{w_dsx[56]}}, w_dsx[56:30]};
    assign w_sumy = {{2{r_y[31]}}, r_y} + {{7{w_dsy[56]}}, w_dsy[56:30]};

    generate
        if (ANGLE_BITS >= 16) begin : g_h_drop
            assign w_h16 = r_heading[ANGLE_BITS-1 -: 16];
        end else begin : g_h_pad
            assign w_h16 = {r_heading, {(16 - ANGLE_BITS){1'b0}}};
        end
    endgenerate

    assign w_out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading   <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                ddpi_pkg::OP_LOAD: begin
                    if (i_ctl.take) begin
                        r_v     <= i_forward_speed;
                        r_dt    <= i_time_step;
                        r_hprod <= i_turn_rate * $signed({1'b0, i_time_step});
                    end
                end
                ddpi_pkg::OP_HEAD: begin
                    r_heading <= n_heading;
                    r_cx      <= ddpi_pkg::CORDIC_GAIN;
                    r_cy      <= '0;
                    r_cz      <= $signed({w_zu[31] ^ w_flip, w_zu[30:0]});
                    r_flip    <= w_flip;
                    r_iter    <= '0;
                end
                ddpi_pkg::OP_ROT: begin
                    if (!r_cz[31]) begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_cz <= r_cz - w_atan;
                    end else begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_cz <= r_cz + w_atan;
                    end
                    r_iter <= ddpi_pkg::t_iter'(r_iter + 1'b1);
                end
                ddpi_pkg::OP_FLIP: begin
                    if (r_flip) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                    end
                end
                ddpi_pkg::OP_MUL1: begin
                    r_px <= r_v * r_cx;
                    r_py <= r_v * r_cy;
                end
                ddpi_pkg::OP_MUL2: begin
                    r_dx <= $signed(w_psx[55:16]) * $signed({1'b0, r_dt});
                    r_dy <= $signed(w_psy[55:16]) * $signed({1'b0, r_dt});
                end
                ddpi_pkg::OP_ACC: begin
                    r_x <= sat32(w_sumx);
                    r_y <= sat32(w_sumy);
                end
                ddpi_pkg::OP_OUT: begin
                    // nothing here; the result register is handled below
                end
            endcase

            // result register: load when free, drop on transfer
            if (i_ctl.op == ddpi_pkg::OP_OUT && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == ddpi_pkg::OP_OUT && !w_out_busy) begin
            r_out_x <= r_x;
            r_out_y <= r_y;
            r_out_h <= w_h16;
        end
    end

    assign o_sts.iter_last = (r_iter == LAST_ITER);
    assign o_sts.out_busy  = w_out_busy;
    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_out_x;
    assign o_pos_y         = r_out_y;
    assign o_heading       = r_out_h;

endmodule

// File: rtl/diff_drive_pose_integrator.sv
// ----------------------------------------------------------------------------
// diff_drive_pose_integrator
// Dead-reckoning pose integrator: heading advances by rate times step, then
// the position moves along the new heading using CORDIC sine and cosine.
//
//   channel   dir  payload                            role
//   i_cmd     in   forward_speed, turn_rate, time_step motion command
//   o_pose    out  pos_x, pos_y, heading               pose after update
//
// One item passes in turn through the load, heading, rotation, flip,
// multiply, accumulate and output steps, using the single CORDIC rotator.
// Synchronous reset clears the pose to zero and empties the result register.
// A finished pose waits in the result register; the next command is taken
// meanwhile and the sequencer holds at its output step only if that pose is
// still not taken when the next one is ready.
// ----------------------------------------------------------------------------
module diff_drive_pose_integrator #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ddpi_cmd_if.sink       i_cmd,
    ddpi_pose_if.source    o_pose
);

    ddpi_pkg::t_ctl w_ctl;
    ddpi_pkg::t_sts w_sts;

    ddpi_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    ddpi_dp #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_forward_speed (i_cmd.forward_speed),
        .i_turn_rate     (i_cmd.turn_rate),
        .i_time_step     (i_cmd.time_step),
        .i_out_ready     (o_pose.ready),
        .o_sts           (w_sts),
        .o_out_valid     (o_pose.valid),
        .o_pos_x         (o_pose.pos_x),
        .o_pos_y         (o_pose.pos_y),
        .o_heading       (o_pose.heading)
    );

    assign i_cmd.ready = w_ctl.ready;

endmodule

// File: rtl/ddpi_chk.sv
// ----------------------------------------------------------------------------
// ddpi_chk
// Port-level checks for the pose integrator, bound to the top level.
// ----------------------------------------------------------------------------
module ddpi_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cmd_valid,
    input logic               i_cmd_ready,
    input logic               i_pose_valid,
    input logic               i_pose_ready,
    input logic signed [31:0] i_pos_x,
    input logic signed [31:0] i_pos_y,
    input logic signed [15:0] i_heading
);

    // a stalled pose holds its payload
    a_pose_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pose_valid && !i_pose_ready) |=>
            ($stable(i_pos_x) && $stable(i_pos_y) && $stable(i_heading)))
        else $error("pose payload changed while stalled");

    // a stalled pose stays valid
    a_pose_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pose_valid && !i_pose_ready) |=> i_pose_valid)
        else $error("pose valid dropped while stalled");

    // one command at a time: after a transfer the block is busy and holds ready low
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> (!i_cmd_ready ##1 !i_cmd_ready))
        else $error("command taken while the previous one is in flight");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pose_valid)
        else $error("pose valid after reset");

endmodule

bind diff_drive_pose_integrator ddpi_chk u_ddpi_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_pose_valid (o_pose.valid),
    .i_pose_ready (o_pose.ready),
    .i_pos_x      (o_pose.pos_x),
    .i_pos_y      (o_pose.pos_y),
    .i_heading    (o_pose.heading)
);
